// File: hdl/fcwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_pkg
// Types and constants shared by the fan duty controller.
// ----------------------------------------------------------------------------
package fcwh_pkg;

    localparam int TEMP_W  = 14;
    localparam int DUTY_W  = 8;
    localparam int HYST_W  = 8;
    localparam int MS_W    = 32;
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 14;
    localparam int DEN_W   = TEMP_W;
    localparam int NUM_W   = TEMP_W + DUTY_W;
    localparam int QUO_W   = DUTY_W;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [DUTY_W-1:0]        t_duty;

    typedef enum logic [OP_W-1:0] {
        OP_TEMP     = 2'd0,
        OP_OVERRIDE = 2'd1,
        OP_TIMED    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [ADDR_W-1:0] {
        REG_ON_TEMP    = 2'd0,
        REG_FULL_TEMP  = 2'd1,
        REG_MIN_DUTY   = 2'd2,
        REG_HYSTERESIS = 2'd3
    } t_reg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIN,
        ST_OUT
    } t_state;

    localparam t_temp ON_TEMP_RST   = 14'sd800;
    localparam t_temp FULL_TEMP_RST = 14'sd960;
    localparam t_duty MIN_DUTY_RST  = 8'd80;
    localparam t_duty HYST_RST      = 8'd32;
    localparam t_duty DUTY_MAX      = 8'd255;

endpackage

// File: hdl/fcwh_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_in_if
// Input item channel: operation, temperature and timing fields.
// ----------------------------------------------------------------------------
interface fcwh_in_if;
    logic                                valid;
    logic                                ready;
    logic [fcwh_pkg::OP_W-1:0]           operation;
    logic signed [fcwh_pkg::TEMP_W-1:0]  temperature;
    logic [fcwh_pkg::DUTY_W-1:0]         duty_request;
    logic [fcwh_pkg::MS_W-1:0]           off_period_ms;
    logic [fcwh_pkg::MS_W-1:0]           now_ms;

    modport source (output valid, operation, temperature, duty_request, off_period_ms,
                    now_ms, input ready);
    modport sink   (input valid, operation, temperature, duty_request, off_period_ms,
                    now_ms, output ready);
endinterface

// File: hdl/fcwh_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_out_if
// Result channel: duty, auto flag and changed flag.
// ----------------------------------------------------------------------------
interface fcwh_out_if;
    logic                         valid;
    logic                         ready;
    logic [fcwh_pkg::DUTY_W-1:0]  duty;
    logic                         auto_mode;
    logic                         duty_changed;

    modport source (output valid, duty, auto_mode, duty_changed, input ready);
    modport sink   (input valid, duty, auto_mode, duty_changed, output ready);
endinterface

// File: hdl/fcwh_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fcwh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fcwh_pkg::ADDR_W-1:0]   addr;
    logic [fcwh_pkg::DATA_W-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// File: hdl/fcwh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_div
// Restoring divider, one quotient bit per cycle. Expects num < den * 2^QUO_W.
// ----------------------------------------------------------------------------
module fcwh_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fcwh_pkg::NUM_W-1:0]   i_num,
    input  logic [fcwh_pkg::DEN_W-1:0]   i_den,
    output logic                         o_done,
    output logic [fcwh_pkg::QUO_W-1:0]   o_quotient
);
    import fcwh_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_low, n_low;
    logic [QUO_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial  = {r_rem, r_low[QUO_W-1]};
        diff   = trial - {1'b0, r_den};
        n_rem  = r_rem;
        n_low  = r_low;
        n_q    = r_q;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_rem = i_num[NUM_W-1:QUO_W];
            n_low = i_num[QUO_W-1:0];
            n_den = i_den;
            n_q   = '0;
            n_cnt = CNT_W'(QUO_W);
        end else if (r_cnt != '0) begin
            if (!diff[DEN_W]) begin
                n_rem = diff[DEN_W-1:0];
                n_q   = {r_q[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DEN_W-1:0];
                n_q   = {r_q[QUO_W-2:0], 1'b0};
            end
            n_low  = {r_low[QUO_W-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_low <= n_low;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: hdl/fan_curve_with_hysteresis.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_curve_with_hysteresis
// Fan duty controller: temperature to PWM duty on a linear curve with a hold
// band, manual override and timed fan-off.
//
// Channels: i_in takes one item (operation, temperature, duty_request,
// off_period_ms, now_ms); o_out gives one result per item (duty, auto_mode,
// duty_changed); i_cfg writes on_temp, full_temp, min_duty and hysteresis
// at indexes 0 to 3 and is always ready.
// Flow: i_in.ready is high only while the sequencer is idle. A ramp
// temperature update passes from acceptance to o_out.valid through the
// compare, one 14x8 multiply, divider load, the serial divider's bit steps,
// its done flag, the final compare, then the result register. Temperature
// updates off the ramp skip the multiply and divider; other items go from
// the compare to the result register. The divider sets the ramp item rate.
// Reset: duty 0, auto mode, no timed deadline, registers at their defaults.
// Stall: a result waits in the output register while o_out.ready is low;
// the next item may be accepted, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module fan_curve_with_hysteresis #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcwh_in_if.sink     i_in,
    fcwh_out_if.source  o_out,
    fcwh_cfg_if.sink    i_cfg
);
    import fcwh_pkg::*;

    localparam int TW = TIME_WIDTH;

    t_state                r_state, n_state;
    t_op                   r_op, n_op;
    t_temp                 r_temp, n_temp;
    t_duty                 r_req, n_req;
    logic [TW-1:0]         r_now, n_now;
    logic [TW-1:0]         r_dur, n_dur;

    t_temp                 r_on_temp, r_full_temp;
    t_duty                 r_min_duty, r_hyst;

    t_duty                 r_duty, n_duty;
    logic                  r_auto, n_auto;
    logic [TW-1:0]         r_deadline, n_deadline;

    t_duty                 r_nd, n_nd;
    logic                  r_changed, n_changed;
    logic [DEN_W-1:0]      r_diff, n_diff;
    logic [DEN_W-1:0]      r_den, n_den;
    t_duty                 r_fac, n_fac;
    logic [NUM_W-1:0]      r_num, n_num;

    logic                  r_out_valid, n_out_valid;
    t_duty                 r_out_duty, n_out_duty;
    logic                  r_out_auto, n_out_auto;
    logic                  r_out_changed, n_out_changed;

    logic                  in_acc;
    logic                  div_start;
    logic                  div_done;
    logic [QUO_W-1:0]      div_q;
    logic [TW-1:0]         elapsed;
    logic [TW-1:0]         off_end;
    logic signed [TEMP_W:0] low_edge;
    logic signed [TEMP_W:0] t_ext;
    logic signed [TEMP_W:0] t_minus_on;
    logic signed [TEMP_W:0] full_minus_on;

    fcwh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_num      (r_num),
        .i_den      (r_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign div_start   = (r_state == ST_DIV_START);

    assign elapsed       = r_now - r_deadline;
    assign off_end       = r_now + r_dur;
    assign t_ext         = (TEMP_W+1)'(r_temp);
    assign low_edge      = (TEMP_W+1)'(r_on_temp) - $signed({1'b0, {(TEMP_W-HYST_W){1'b0}}, r_hyst});
    assign t_minus_on    = t_ext - (TEMP_W+1)'(r_on_temp);
    assign full_minus_on = (TEMP_W+1)'(r_full_temp) - (TEMP_W+1)'(r_on_temp);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_temp        = r_temp;
        n_req         = r_req;
        n_now         = r_now;
        n_dur         = r_dur;
        n_duty        = r_duty;
        n_auto        = r_auto;
        n_deadline    = r_deadline;
        n_nd          = r_nd;
        n_changed     = r_changed;
        n_diff        = r_diff;
        n_den         = r_den;
        n_fac         = r_fac;
        n_num         = r_num;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_duty    = r_out_duty;
        n_out_auto    = r_out_auto;
        n_out_changed = r_out_changed;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_op      = t_op'(i_in.operation);
                    n_temp    = i_in.temperature;
                    n_req     = i_in.duty_request;
                    n_now     = TW'(i_in.now_ms);
                    n_dur     = TW'(i_in.off_period_ms);
                    n_changed = 1'b0;
                    n_state   = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_state = ST_OUT;
                case (r_op)
                    OP_TEMP: begin
                        if (r_auto || (r_deadline != '0 && !elapsed[TW-1])) begin
                            n_auto     = 1'b1;
                            if (!r_auto) begin
                                n_deadline = '0;
                            end
                            n_state = ST_FIN;
                            if (t_ext < low_edge) begin
                                n_nd = '0;
                            end else if (r_temp < r_on_temp) begin
                                n_nd = r_duty;
                            end else if (r_temp >= r_full_temp) begin
                                n_nd = DUTY_MAX;
                            end else begin
                                n_diff  = t_minus_on[DEN_W-1:0];
                                n_den   = full_minus_on[DEN_W-1:0];
                                n_fac   = DUTY_MAX - r_min_duty;
                                n_state = ST_MUL;
                            end
                        end
                    end
                    OP_OVERRIDE: begin
                        n_deadline = '0;
                        if (r_req == '0) begin
                            n_auto = 1'b1;
                        end else begin
                            n_auto    = 1'b0;
                            n_duty    = r_req;
                            n_changed = 1'b1;
                        end
                    end
                    OP_TIMED: begin
                        n_auto     = 1'b0;
                        n_duty     = '0;
                        n_changed  = 1'b1;
                        n_deadline = (off_end == '0) ? TW'(1) : off_end;
                    end
                    default: begin
                    end
                endcase
            end
            ST_MUL: begin
                n_num   = NUM_W'(r_diff) * NUM_W'(r_fac);
                n_state = ST_DIV_START;
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_nd    = r_min_duty + div_q;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_nd != r_duty) begin
                    n_duty    = r_nd;
                    n_changed = 1'b1;
                end
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_duty    = r_duty;
                    n_out_auto    = r_auto;
                    n_out_changed = r_changed;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_duty      <= '0;
            r_auto      <= 1'b1;
            r_deadline  <= '0;
            r_out_valid <= 1'b0;
            r_on_temp   <= ON_TEMP_RST;
            r_full_temp <= FULL_TEMP_RST;
            r_min_duty  <= MIN_DUTY_RST;
            r_hyst      <= HYST_RST;
        end else begin
            r_state     <= n_state;
            r_duty      <= n_duty;
            r_auto      <= n_auto;
            r_deadline  <= n_deadline;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (t_reg_addr'(i_cfg.addr))
                    REG_ON_TEMP:    r_on_temp   <= i_cfg.data;
                    REG_FULL_TEMP:  r_full_temp <= i_cfg.data;
                    REG_MIN_DUTY:   r_min_duty  <= i_cfg.data[DUTY_W-1:0];
                    REG_HYSTERESIS: r_hyst      <= i_cfg.data[HYST_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_temp        <= n_temp;
        r_req         <= n_req;
        r_now         <= n_now;
        r_dur         <= n_dur;
        r_nd          <= n_nd;
        r_changed     <= n_changed;
        r_diff        <= n_diff;
        r_den         <= n_den;
        r_fac         <= n_fac;
        r_num         <= n_num;
        r_out_duty    <= n_out_duty;
        r_out_auto    <= n_out_auto;
        r_out_changed <= n_out_changed;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.duty         = r_out_duty;
    assign o_out.auto_mode    = r_out_auto;
    assign o_out.duty_changed = r_out_changed;

    a_deadline_manual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_deadline != '0) |-> !r_auto)
        else $error("timed deadline pending in auto mode");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_EVAL))
        else $error("accepted transaction not evaluated");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider finished outside wait state");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && (!r_out_valid || o_out.ready)) |=> o_out.valid)
        else $error("result not presented");

endmodule

// File: bench/fcwh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcwh_checker
// Watches the item, result and register channels of the fan duty controller.
// It keeps its own copy of the thresholds, duty, mode and off deadline, works
// out the expected result of every accepted item and compares each accepted
// result, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module fcwh_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    fcwh_in_if   i_in,
    fcwh_out_if  i_out,
    fcwh_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    import fcwh_pkg::*;

    typedef struct packed {
        t_duty duty;
        logic  auto_mode;
        logic  duty_changed;
    } t_fan_result;

    int              on_temp;
    int              full_temp;
    int              min_duty;
    int              hysteresis;
    t_duty           duty_q;
    logic            auto_q;
    logic [MS_W-1:0] deadline_q;
    t_fan_result     fan_results_q[$];

    task automatic report(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        o_fail_count++;
    endtask

    function automatic t_duty curve_duty(int t);
        int num;
        int den;
        if (t < on_temp - hysteresis) return '0;
        if (t < on_temp) return duty_q;
        if (t >= full_temp) return DUTY_MAX;
        num = (t - on_temp) * (int'(DUTY_MAX) - min_duty);
        den = full_temp - on_temp;
        return t_duty'(min_duty + num / den);
    endfunction

    function automatic t_fan_result apply_item(t_op op, int t, t_duty req,
                                               logic [MS_W-1:0] dur,
                                               logic [MS_W-1:0] now);
        t_fan_result     r;
        logic [MS_W-1:0] elapsed;
        logic [MS_W-1:0] stop_at;
        logic            run;
        t_duty           nd;
        r.duty_changed = 1'b0;
        case (op)
            OP_TEMP: begin
                run = 1'b1;
                elapsed = now - deadline_q;
                if (!auto_q) begin
                    if (deadline_q != '0 && !elapsed[MS_W-1]) begin
                        auto_q = 1'b1;
                        deadline_q = '0;
                    end else begin
                        run = 1'b0;
                    end
                end
                if (run) begin
                    nd = curve_duty(t);
                    if (nd != duty_q) begin
                        duty_q = nd;
                        r.duty_changed = 1'b1;
                    end
                end
            end
            OP_OVERRIDE: begin
                deadline_q = '0;
                if (req == '0) begin
                    auto_q = 1'b1;
                end else begin
                    auto_q = 1'b0;
                    duty_q = req;
                    r.duty_changed = 1'b1;
                end
            end
            OP_TIMED: begin
                stop_at = now + dur;
                auto_q = 1'b0;
                duty_q = '0;
                r.duty_changed = 1'b1;
                if (stop_at == '0) stop_at = 1;
                deadline_q = stop_at;
            end
            default: ;
        endcase
        r.duty = duty_q;
        r.auto_mode = auto_q;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fan_result want;
        if (!i_rst_n) begin
            on_temp = int'(ON_TEMP_RST);
            full_temp = int'(FULL_TEMP_RST);
            min_duty = int'(MIN_DUTY_RST);
            hysteresis = int'(HYST_RST);
            duty_q = '0;
            auto_q = 1'b1;
            deadline_q = '0;
            fan_results_q.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_reg_addr'(i_cfg.addr))
                    REG_ON_TEMP:    on_temp = int'($signed(i_cfg.data));
                    REG_FULL_TEMP:  full_temp = int'($signed(i_cfg.data));
                    REG_MIN_DUTY:   min_duty = int'(i_cfg.data[DUTY_W-1:0]);
                    REG_HYSTERESIS: hysteresis = int'(i_cfg.data[HYST_W-1:0]);
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                fan_results_q.push_back(apply_item(t_op'(i_in.operation),
                                                   int'($signed(i_in.temperature)),
                                                   i_in.duty_request, i_in.off_period_ms,
                                                   i_in.now_ms));
            end
            if (i_out.valid && i_out.ready) begin
                if (fan_results_q.size() == 0) begin
                    report($sformatf("result with none expected: duty %0d auto %0b changed %0b",
                                     i_out.duty, i_out.auto_mode, i_out.duty_changed));
                end else begin
                    want = fan_results_q.pop_front();
                    o_checked++;
                    if (i_out.duty !== want.duty)
                        report($sformatf("duty got %0d expected %0d",
                                         i_out.duty, want.duty));
                    if (i_out.auto_mode !== want.auto_mode)
                        report($sformatf("auto_mode got %0b expected %0b",
                                         i_out.auto_mode, want.auto_mode));
                    if (i_out.duty_changed !== want.duty_changed)
                        report($sformatf("duty_changed got %0b expected %0b",
                                         i_out.duty_changed, want.duty_changed));
                end
            end
        end
        o_pending = fan_results_q.size();
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the fan duty controller. A directed pass covers
// curve edges, the hold band, overrides, timed fan-off with deadline wrap and
// the ignored operation; random passes then run under several threshold
// settings, with random gaps on both channels and none in the last setting.
// ----------------------------------------------------------------------------
module testbench;
    import fcwh_pkg::*;

    localparam int TEMP_MIN = -(1 << (TEMP_W - 1));
    localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
    localparam int N_PHASES = 7;
    localparam int PHASE_ITEMS = 133;

    logic i_clk;
    logic i_rst_n;

    fcwh_in_if  in_if ();
    fcwh_out_if out_if ();
    fcwh_cfg_if cfg_if ();

    int              fail_count;
    int              pending;
    int              checked;
    logic            idle_on;
    int              stall_left;
    int              op_count[4];
    int              reg_writes;
    int              cur_on;
    int              cur_full;
    int              cur_hyst;
    logic [MS_W-1:0] clock_ms;

    int phase_on[N_PHASES]   = '{800, -8192, 8191, 100, -50, 0, 1500};
    int phase_full[N_PHASES] = '{960, 8191, -8192, 100, 10, 1, 3000};
    int phase_min[N_PHASES]  = '{80, 0, 255, 200, 255, 1, 80};
    int phase_hyst[N_PHASES] = '{32, 0, 255, 7, 255, 100, 16};

    fan_curve_with_hysteresis #(
        .TIME_WIDTH(MS_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    fcwh_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout: results still outstanding");
        $display("Some tests failed");
        $finish;
    end

    // result side back-pressure
    initial begin
        out_if.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_if.ready = 1'b1;
            end
        end
    end

    function automatic int clamp_temp(int t);
        if (t < TEMP_MIN) return TEMP_MIN;
        if (t > TEMP_MAX) return TEMP_MAX;
        return t;
    endfunction

    function automatic int rand_temp();
        int lo;
        int hi;
        case ($urandom_range(0, 5))
            0: return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
            1: return clamp_temp(cur_on - cur_hyst - 4
                                 + int'($urandom_range(0, cur_hyst + 8)));
            2: return clamp_temp(cur_full - 4 + int'($urandom_range(0, 8)));
            default: begin
                lo = cur_on - cur_hyst - 64;
                hi = cur_full + 64;
                if (hi < lo) begin
                    lo = cur_full - 64;
                    hi = cur_on + 64;
                end
                return clamp_temp(lo + int'($urandom_range(0, hi - lo)));
            end
        endcase
    endfunction

    task automatic write_reg(t_reg_addr addr, int value);
        @(negedge i_clk);
        cfg_if.addr = addr;
        cfg_if.data = value[DATA_W-1:0];
        cfg_if.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        reg_writes++;
    endtask

    task automatic send_item(t_op op, int t, t_duty req, logic [MS_W-1:0] dur,
                             logic [MS_W-1:0] now);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.operation = op;
        in_if.temperature = t[TEMP_W-1:0];
        in_if.duty_request = req;
        in_if.off_period_ms = dur;
        in_if.now_ms = now;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        op_count[op]++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic random_item();
        int              pick;
        t_duty           req;
        logic [MS_W-1:0] dur;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            clock_ms += $urandom_range(0, 40);
            send_item(OP_TEMP, rand_temp(), t_duty'($urandom), $urandom, clock_ms);
        end else if (pick < 75) begin
            req = ($urandom_range(0, 3) == 0) ? '0 : t_duty'($urandom_range(1, 255));
            send_item(OP_OVERRIDE, rand_temp(), req, $urandom, clock_ms);
        end else if (pick < 92) begin
            if ($urandom_range(0, 9) == 0)
                clock_ms = $urandom_range(0, 1) ? $urandom
                                                : ~MS_W'(0) - $urandom_range(0, 300);
            dur = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200);
            send_item(OP_TIMED, rand_temp(), t_duty'($urandom), dur, clock_ms);
        end else if (pick < 96) begin
            send_item(OP_NONE, rand_temp(), t_duty'($urandom), $urandom, $urandom);
        end else begin
            send_item(OP_TEMP, rand_temp(), t_duty'($urandom), $urandom, $urandom);
        end
    endtask

    task automatic run_directed();
        send_item(OP_TEMP, 700, '0, '0, 32'd10);
        send_item(OP_TEMP, 800, '0, '0, 32'd10);
        send_item(OP_TEMP, 780, '0, '0, 32'd10);
        send_item(OP_TEMP, 959, '0, '0, 32'd10);
        send_item(OP_TEMP, 960, '0, '0, 32'd10);
        send_item(OP_TEMP, TEMP_MAX, '0, '0, 32'd10);
        send_item(OP_TEMP, TEMP_MIN, '0, '0, 32'd10);
        send_item(OP_TEMP, 768, '0, '0, 32'd10);
        send_item(OP_TEMP, 767, '0, '0, 32'd10);
        send_item(OP_OVERRIDE, 0, 8'd255, '0, 32'd10);
        send_item(OP_TEMP, 900, 8'd255, '0, 32'd10);
        send_item(OP_OVERRIDE, 0, 8'd255, '0, 32'd10);
        send_item(OP_OVERRIDE, 900, 8'd0, '0, 32'd10);
        send_item(OP_TIMED, 900, '0, 32'd50, 32'd100);
        send_item(OP_TEMP, 900, '0, '0, 32'd149);
        send_item(OP_TEMP, 900, '0, '0, 32'd150);
        send_item(OP_TIMED, 900, '0, 32'h0000_0010, 32'hFFFF_FFF0);
        send_item(OP_TEMP, 900, '0, '0, 32'd0);
        send_item(OP_TEMP, 900, '0, '0, 32'd1);
        send_item(OP_TIMED, 900, '0, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_item(OP_TEMP, 900, '0, '0, 32'hFFFF_FFFF);
        send_item(OP_NONE, TEMP_MAX, 8'hA5, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_item(OP_OVERRIDE, 0, 8'd1, '0, 32'd0);
        send_item(OP_TEMP, 900, '0, '0, 32'h8000_0000);
        send_item(OP_TIMED, 0, '0, 32'd0, 32'd0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        idle_on = 1'b1;
        in_if.valid = 1'b0;
        in_if.operation = OP_TEMP;
        in_if.temperature = '0;
        in_if.duty_request = '0;
        in_if.off_period_ms = '0;
        in_if.now_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.addr = REG_ON_TEMP;
        cfg_if.data = '0;
        reg_writes = 0;
        clock_ms = '0;
        foreach (op_count[i]) op_count[i] = 0;
        cur_on = int'(ON_TEMP_RST);
        cur_full = int'(FULL_TEMP_RST);
        cur_hyst = int'(HYST_RST);
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == N_PHASES - 1) idle_on = 1'b0;
            write_reg(REG_ON_TEMP, phase_on[p]);
            write_reg(REG_FULL_TEMP, phase_full[p]);
            write_reg(REG_MIN_DUTY, phase_min[p]);
            write_reg(REG_HYSTERESIS, phase_hyst[p]);
            cur_on = phase_on[p];
            cur_full = phase_full[p];
            cur_hyst = phase_hyst[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if (idle_on && $urandom_range(0, 59) == 0) drain();
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        $display("items: %0d temperature updates, %0d overrides, %0d timed-off, %0d ignored",
                 op_count[OP_TEMP], op_count[OP_OVERRIDE], op_count[OP_TIMED],
                 op_count[OP_NONE]);
        $display("%0d register writes over %0d threshold settings, %0d results compared",
                 reg_writes, N_PHASES, checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/fcwh_pkg.sv
hdl/fcwh_in_if.sv
hdl/fcwh_out_if.sv
hdl/fcwh_cfg_if.sv
hdl/fcwh_div.sv
hdl/fan_curve_with_hysteresis.sv
bench/fcwh_checker.sv
bench/testbench.sv
